// ----- hdl/bqc_pkg.sv -----
// ----------------------------------------------------------------------------
// bqc_pkg
// shared types and constants of the biquad cascade filter
// ----------------------------------------------------------------------------
`default_nettype none

package bqc_pkg;

    localparam int SAMPLE_W         = 24;
    localparam int COEF_W           = 32;
    localparam int NUM_W            = 4;
    localparam int ADDR_W           = 6;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 32;
    localparam int COEFS_PER_STAGE  = 5;
    localparam int DELAYS_PER_STAGE = 4;
    localparam int DLY_W            = DELAYS_PER_STAGE * SAMPLE_W;
    localparam int PROD_W           = COEF_W + SAMPLE_W;
    localparam int ACC_W            = PROD_W + 2;
    localparam int FRAC_SHIFT       = 30;
    localparam int Q_W              = ACC_W - FRAC_SHIFT;

    // coefficient address split: stage = (addr * 13) >> 6, exact for 6-bit addresses
    localparam int RECIP_MUL   = 13;
    localparam int RECIP_SHIFT = 6;
    localparam int RECIP_W     = ADDR_W + 4;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_STAGES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ADDR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_DATA  = 2'd2;

    localparam logic [NUM_W-1:0]  NUM_STAGES_RST = 4'd1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [ACC_W-1:0]    ROUND_BIAS = ACC_W'(1) << (FRAC_SHIFT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD1,
        ST_ADD2,
        ST_ADD3,
        ST_SAT
    } t_state;

    typedef struct packed {
        logic load_x;
        logic rd_en;
        logic mul;
        logic add1;
        logic add2;
        logic add3;
        logic sat_wr;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
        logic out_taken;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- hdl/bqc_if.sv -----
// ----------------------------------------------------------------------------
// bqc stream interfaces
// valid/ready channels for input samples and filtered results
// ----------------------------------------------------------------------------
`default_nettype none

interface bqc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bqc_pkg::SAMPLE_W-1:0]  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bqc_pkg::SAMPLE_W-1:0]  sample_out;
    logic                                 saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

`default_nettype wire

// ----- hdl/bqc_ram.sv -----
// ----------------------------------------------------------------------------
// bqc_ram
// generic single write port ram with registered, enabled read
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bqc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bqc_ctrl
// sequencer that walks the active stages, five steps per stage
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_ctrl #(
    parameter int MAX_STAGES = 8
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_in_valid,
    output logic                                                o_in_ready,
    input  wire logic [(MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1)-1:0] i_last_stage,
    input  wire bqc_pkg::t_dp_sts                               i_sts,
    output bqc_pkg::t_dp_cmd                                    o_cmd,
    output logic [(MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1)-1:0] o_stage,
    output logic [(MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1)-1:0] o_rd_stage
);

    localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    bqc_pkg::t_state r_state, n_state;
    logic [SW-1:0]   r_stage, n_stage;
    logic            w_is_last;
    logic            w_out_blocked;

    assign w_is_last     = (r_stage == i_last_stage);
    assign w_out_blocked = i_sts.out_full && !i_sts.out_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bqc_pkg::ST_IDLE;
            r_stage <= '0;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_stage = r_stage;
        case (r_state)
            bqc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = bqc_pkg::ST_MUL;
                    n_stage = '0;
                end
            end
            bqc_pkg::ST_MUL:  n_state = bqc_pkg::ST_ADD1;
            bqc_pkg::ST_ADD1: n_state = bqc_pkg::ST_ADD2;
            bqc_pkg::ST_ADD2: n_state = bqc_pkg::ST_ADD3;
            bqc_pkg::ST_ADD3: begin
                if (!(w_is_last && w_out_blocked)) begin
                    n_state = bqc_pkg::ST_SAT;
                end
            end
            bqc_pkg::ST_SAT: begin
                if (w_is_last) begin
                    n_state = bqc_pkg::ST_IDLE;
                end else begin
                    n_state = bqc_pkg::ST_MUL;
                    n_stage = r_stage + SW'(1);
                end
            end
            default: n_state = bqc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_rd_stage = '0;
        case (r_state)
            bqc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_x = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                end
            end
            bqc_pkg::ST_MUL:  o_cmd.mul  = 1'b1;
            bqc_pkg::ST_ADD1: o_cmd.add1 = 1'b1;
            bqc_pkg::ST_ADD2: o_cmd.add2 = 1'b1;
            bqc_pkg::ST_ADD3: o_cmd.add3 = 1'b1;
            bqc_pkg::ST_SAT: begin
                o_cmd.sat_wr = 1'b1;
                if (w_is_last) begin
                    o_cmd.load_out = 1'b1;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_stage  = r_stage + SW'(1);
                end
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_stage = r_stage;

    a_load_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !w_out_blocked)
        else $error("result loaded over an untaken word");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == bqc_pkg::ST_MUL && r_stage == '0))
        else $error("accepted word did not start at the first stage");

    a_stage_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bqc_pkg::ST_IDLE) |-> (r_stage <= i_last_stage))
        else $error("stage counter ran past the last active stage");

endmodule

`default_nettype wire

// ----- hdl/bqc_datapath.sv -----
// ----------------------------------------------------------------------------
// bqc_datapath
// coefficient and delay storage, five multipliers, adder steps, rounding,
// saturation and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_datapath #(
    parameter int MAX_STAGES = 8
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_cfg_we,
    input  wire logic [bqc_pkg::CFG_IDX_W-1:0]                  i_cfg_idx,
    input  wire logic [bqc_pkg::CFG_DATA_W-1:0]                 i_cfg_data,
    input  wire logic signed [bqc_pkg::SAMPLE_W-1:0]            i_sample_in,
    input  wire bqc_pkg::t_dp_cmd                               i_cmd,
    input  wire logic [(MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1)-1:0] i_stage,
    input  wire logic [(MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1)-1:0] i_rd_stage,
    output logic [(MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1)-1:0] o_last_stage,
    output bqc_pkg::t_dp_sts                                    o_sts,
    input  wire logic                                           i_out_ready,
    output logic                                                o_out_valid,
    output logic signed [bqc_pkg::SAMPLE_W-1:0]                 o_sample_out,
    output logic                                                o_saturated
);

    localparam int SW  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int NC  = bqc_pkg::COEFS_PER_STAGE;
    localparam int SMW = bqc_pkg::SAMPLE_W;

    // configuration registers
    logic [bqc_pkg::NUM_W-1:0]  r_num_stages;
    logic [bqc_pkg::ADDR_W-1:0] r_coef_addr;
    logic                       w_wr_num;
    logic                       w_wr_coef;

    assign w_wr_num  = i_cfg_we && (i_cfg_idx == bqc_pkg::REG_NUM_STAGES);
    assign w_wr_coef = i_cfg_we && (i_cfg_idx == bqc_pkg::REG_COEF_DATA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_stages <= bqc_pkg::NUM_STAGES_RST;
            r_coef_addr  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bqc_pkg::REG_NUM_STAGES) begin
                r_num_stages <= i_cfg_data[bqc_pkg::NUM_W-1:0];
            end
            if (i_cfg_idx == bqc_pkg::REG_COEF_ADDR) begin
                r_coef_addr <= i_cfg_data[bqc_pkg::ADDR_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_num_stages == '0) begin
            o_last_stage = '0;
        end else if (int'(r_num_stages) > MAX_STAGES) begin
            o_last_stage = SW'(MAX_STAGES - 1);
        end else begin
            o_last_stage = SW'(r_num_stages - bqc_pkg::NUM_W'(1));
        end
    end

    // coefficient address split into stage and slot
    logic [bqc_pkg::RECIP_W-1:0] w_recip;
    logic [3:0]                  w_wq;
    logic [bqc_pkg::ADDR_W-1:0]  w_wq5;
    logic [bqc_pkg::ADDR_W-1:0]  w_wrem;
    logic [2:0]                  w_wslot;
    logic                        w_wq_ok;
    logic [SW-1:0]               w_wstage;

    assign w_recip  = bqc_pkg::RECIP_W'(r_coef_addr) * bqc_pkg::RECIP_W'(bqc_pkg::RECIP_MUL);
    assign w_wq     = w_recip[bqc_pkg::RECIP_W-1:bqc_pkg::RECIP_SHIFT];
    assign w_wq5    = bqc_pkg::ADDR_W'(w_wq) * bqc_pkg::ADDR_W'(NC);
    assign w_wrem   = r_coef_addr - w_wq5;
    assign w_wslot  = w_wrem[2:0];
    assign w_wq_ok  = int'(w_wq) < MAX_STAGES;
    assign w_wstage = SW'(w_wq);

    // coefficient rams, one per slot, with valid bits
    logic [MAX_STAGES-1:0]            r_coef_vld [NC];
    logic                             r_cv_q [NC];
    logic [bqc_pkg::COEF_W-1:0]       w_coef_rd [NC];
    logic signed [bqc_pkg::COEF_W-1:0] w_coef [NC];

    for (genvar k = 0; k < NC; k++) begin : g_coef
        logic w_we;
        assign w_we = w_wr_coef && w_wq_ok && (w_wslot == 3'(k));

        bqc_ram #(
            .WIDTH (bqc_pkg::COEF_W),
            .DEPTH (MAX_STAGES)
        ) u_coef_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_wstage),
            .i_wdata (i_cfg_data),
            .i_re    (i_cmd.rd_en),
            .i_raddr (i_rd_stage),
            .o_rdata (w_coef_rd[k])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_coef_vld[k] <= '0;
            end else if (w_we) begin
                r_coef_vld[k][w_wstage] <= 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.rd_en) begin
                r_cv_q[k] <= r_coef_vld[k][i_rd_stage];
            end
        end

        assign w_coef[k] = r_cv_q[k] ? signed'(w_coef_rd[k]) : '0;
    end

    // delay ram, one row per stage: {y2, y1, x2, x1}
    logic [MAX_STAGES-1:0]      r_dly_vld;
    logic                       r_dv_q;
    logic [bqc_pkg::DLY_W-1:0]  w_dly_rd;
    logic [bqc_pkg::DLY_W-1:0]  w_dly;
    logic [bqc_pkg::DLY_W-1:0]  w_dly_wr;
    logic signed [SMW-1:0]      w_x1, w_x2, w_y1, w_y2;

    bqc_ram #(
        .WIDTH (bqc_pkg::DLY_W),
        .DEPTH (MAX_STAGES)
    ) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sat_wr),
        .i_waddr (i_stage),
        .i_wdata (w_dly_wr),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_stage),
        .o_rdata (w_dly_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_wr_num) begin
            r_dly_vld <= '0;
        end else if (i_cmd.sat_wr) begin
            r_dly_vld[i_stage] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_dv_q <= r_dly_vld[i_rd_stage];
        end
    end

    assign w_dly = r_dv_q ? w_dly_rd : '0;
    assign w_x1  = signed'(w_dly[SMW-1:0]);
    assign w_x2  = signed'(w_dly[2*SMW-1:SMW]);
    assign w_y1  = signed'(w_dly[3*SMW-1:2*SMW]);
    assign w_y2  = signed'(w_dly[4*SMW-1:3*SMW]);

    // arithmetic
    logic signed [SMW-1:0]                r_x;
    logic                                 r_flag;
    logic signed [bqc_pkg::PROD_W-1:0]    r_p [NC];
    logic signed [bqc_pkg::ACC_W-1:0]     r_s0, r_s1, r_s2, r_acc;
    logic [bqc_pkg::Q_W-1:0]              w_q;
    logic [bqc_pkg::Q_W-SMW:0]            w_top;
    logic                                 w_fits;
    logic signed [SMW-1:0]                w_y;

    assign w_q    = r_acc[bqc_pkg::ACC_W-1:bqc_pkg::FRAC_SHIFT];
    assign w_top  = w_q[bqc_pkg::Q_W-1:SMW-1];
    assign w_fits = (&w_top) || !(|w_top);

    always_comb begin
        if (w_fits) begin
            w_y = signed'(w_q[SMW-1:0]);
        end else if (w_q[bqc_pkg::Q_W-1]) begin
            w_y = bqc_pkg::SAMPLE_MIN;
        end else begin
            w_y = bqc_pkg::SAMPLE_MAX;
        end
    end

    assign w_dly_wr = {w_y1, w_y, w_x1, r_x};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x    <= i_sample_in;
            r_flag <= 1'b0;
        end else if (i_cmd.sat_wr) begin
            r_x    <= w_y;
            r_flag <= r_flag || !w_fits;
        end
        if (i_cmd.mul) begin
            r_p[0] <= w_coef[0] * r_x;
            r_p[1] <= w_coef[1] * w_x1;
            r_p[2] <= w_coef[2] * w_x2;
            r_p[3] <= w_coef[3] * w_y1;
            r_p[4] <= w_coef[4] * w_y2;
        end
        if (i_cmd.add1) begin
            r_s0 <= bqc_pkg::ACC_W'(r_p[0]) + bqc_pkg::ACC_W'(r_p[1]);
            r_s1 <= bqc_pkg::ACC_W'(r_p[2]) + bqc_pkg::ACC_W'(r_p[3]);
            r_s2 <= bqc_pkg::ACC_W'(r_p[4]) + bqc_pkg::ROUND_BIAS;
        end
        if (i_cmd.add2) begin
            r_s0 <= r_s0 + r_s1;
        end
        if (i_cmd.add3) begin
            r_acc <= r_s0 + r_s2;
        end
    end

    // result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_sample_out <= w_y;
            o_saturated  <= r_flag || !w_fits;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sts.out_full  = r_out_valid;
    assign o_sts.out_taken = r_out_valid && i_out_ready;

    a_row_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sat_wr && !w_wr_num) |=> r_dly_vld[$past(i_stage)])
        else $error("written delay row not marked valid");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- hdl/biquad_cascade_df1_filter_unit.sv -----
// ----------------------------------------------------------------------------
// biquad_cascade_df1_filter_unit
// cascade of direct form I biquad sections on signed q0.23 samples
// ----------------------------------------------------------------------------
// One word is filtered at a time. Each active stage runs five steps on the
// shared set of five multipliers (multiply, three adder steps, round and
// saturate with delay write-back); the last stage stalls before rounding while
// the output register holds an untaken result. A finished result sits in an
// output register, so the next sample is taken while it waits. Coefficients
// and delays reset to zero; writing num_stages clears all delays at once.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_cascade_df1_filter_unit #(
    parameter int MAX_STAGES = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bqc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [bqc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    bqc_in_if.sink                                  i_in,
    bqc_out_if.source                               o_out
);

    localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    bqc_pkg::t_dp_cmd w_cmd;
    bqc_pkg::t_dp_sts w_sts;
    logic [SW-1:0]    w_stage;
    logic [SW-1:0]    w_rd_stage;
    logic [SW-1:0]    w_last_stage;

    bqc_ctrl #(
        .MAX_STAGES (MAX_STAGES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (i_in.ready),
        .i_last_stage (w_last_stage),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_stage      (w_stage),
        .o_rd_stage   (w_rd_stage)
    );

    bqc_datapath #(
        .MAX_STAGES (MAX_STAGES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_in.sample_in),
        .i_cmd        (w_cmd),
        .i_stage      (w_stage),
        .i_rd_stage   (w_rd_stage),
        .o_last_stage (w_last_stage),
        .o_sts        (w_sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_sample_out (o_out.sample_out),
        .o_saturated  (o_out.saturated)
    );

endmodule

`default_nettype wire
